>>> src/eth_ip_tcp_header_parser_defines.svh
// Assertion macros for the header parser checker.
`ifndef ETH_IP_TCP_HEADER_PARSER_DEFINES_SVH
`define ETH_IP_TCP_HEADER_PARSER_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define EITHP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
// Assert that a condition holds at every edge out of reset.
`define EITHP_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`endif

>>> src/eithp_pkg.sv
// Package: shared types and constants of the header parser.
`default_nettype none
package eithp_pkg;
  localparam int unsigned MaxFrameBytesDefault = 2048;
  localparam logic [15:0] EtherArp  = 16'h0806;
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoIcmp = 8'h01;
  localparam logic [7:0]  ProtoTcp  = 8'h06;
  localparam logic [7:0]  ProtoUdp  = 8'h11;

  localparam logic [2:0] ClsUnknown = 3'd0;
  localparam logic [2:0] ClsArp     = 3'd1;
  localparam logic [2:0] ClsIpOther = 3'd2;
  localparam logic [2:0] ClsIcmp    = 3'd3;
  localparam logic [2:0] ClsTcp     = 3'd4;
  localparam logic [2:0] ClsUdp     = 3'd5;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  packet_class;
    logic        arp_is_reply;
    logic [5:0]  ip_header_bytes;
    logic [7:0]  time_to_live;
    logic        ip_sum_good;
    logic        tcp_sum_good;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  tcp_flag_bits;
    logic [7:0]  icmp_type_code;
    logic        truncated;
  } out_item_t;

  // Frame summary passed from the byte front end to the result back end.
  typedef struct packed {
    logic        short_frame;
    logic [15:0] ether_kind;
    logic [3:0]  header_words;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [15:0] ip_sum_acc;
    logic [15:0] tcp_sum_acc;
    logic [63:0] captured;
    logic        ip_hdr_done;   // count >= 14 + hlen
    logic        l4_8_done;     // count >= 14 + hlen + 8
    logic        l4_20_done;    // count >= 14 + hlen + 20
    logic        tot_done;      // count >= 14 + total length
    logic        ip20_done;     // count >= 34
    logic        arp_done;      // count >= 42
  } summary_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction
endpackage
`default_nettype wire

>>> src/eithp_front.sv
// Front end: byte walker that decodes fields and accumulates checksums.
`default_nettype none
module eithp_front import eithp_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire in_item_t item_i,
  output logic          ready_o,
  output logic          sum_valid_o,
  output summary_t      sum_o,
  input  wire logic     sum_ready_i
);
  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0] kind_q, kind_d, tot_q, tot_d, ips_q, ips_d, tcps_q, tcps_d;
  logic [3:0]  hw_q, hw_d;
  logic [7:0]  prot_q, prot_d, pend_q, pend_d;
  logic [63:0] cap_q, cap_d;
  logic        take;

  // Hold off only a last byte while the summary has nowhere to go.
  assign ready_o     = sum_ready_i || !item_i.frame_end;
  assign take        = valid_i && ready_o;
  assign sum_valid_o = take && item_i.frame_end;

  always_comb begin
    logic [CntW-1:0] pos;
    logic [CntW:0]   i, hlen, j;
    logic [15:0]     word;
    logic            odd;
    logic [7:0]      b;
    logic [CntW+1:0] cnt_n;
    b = item_i.frame_byte;
    pos = cnt_q;
    hlen = '0;
    j = '0;
    cnt_d = cnt_q; kind_d = kind_q; hw_d = hw_q; tot_d = tot_q; prot_d = prot_q;
    ips_d = ips_q; tcps_d = tcps_q; pend_d = pend_q; cap_d = cap_q;
    i = {1'b0, pos} - (CntW+1)'(14);
    odd = i[0];
    word = {pend_q, b};
    if ({1'b0, pos} < (CntW+1)'(MaxFrameBytes)) begin
      cnt_d = pos + 1'b1;
      if (pos == CntW'(12)) kind_d = {b, 8'd0};
      else if (pos == CntW'(13)) kind_d = {kind_q[15:8], b};
      else if (pos >= CntW'(14)) begin
        if (kind_q == EtherArp) begin
          if (pos == CntW'(20)) cap_d[15:8] = b;
          if (pos == CntW'(21)) cap_d[7:0] = b;
        end else if (kind_q == EtherIpv4) begin
          hlen = (CntW+1)'({hw_q, 2'b00});
          if (i == '0) begin
            hw_d = b[3:0];
            hlen = (CntW+1)'({b[3:0], 2'b00});
          end
          if (i == (CntW+1)'(2)) tot_d = {b, 8'd0};
          if (i == (CntW+1)'(3)) tot_d = {tot_q[15:8], b};
          if (i == (CntW+1)'(8)) cap_d[55:48] = b;
          if (i == (CntW+1)'(9)) prot_d = b;
          if (odd && hw_d >= 4'd5 && i < hlen) ips_d = oc_add(ips_q, word);
          if (odd && i >= (CntW+1)'(12) && i <= (CntW+1)'(19))
            tcps_d = oc_add(tcps_q, word);
          if (hw_d >= 4'd5 && i >= hlen) begin
            j = i - hlen;
            if (j == '0) begin cap_d[15:8] = b; cap_d[47:40] = b; end
            if (j == (CntW+1)'(1)) cap_d[7:0] = b;
            if (j == (CntW+1)'(2)) cap_d[31:24] = b;
            if (j == (CntW+1)'(3)) cap_d[23:16] = b;
            if (j == (CntW+1)'(13)) cap_d[39:32] = b;
            if (17'(i) < {1'b0, tot_q}) begin
              if (odd) tcps_d = oc_add(tcps_d, word);
              else if (17'(i) + 17'd1 == {1'b0, tot_q})
                tcps_d = oc_add(tcps_d, {b, 8'd0});
            end
          end
          if (!odd) pend_d = b;
        end
      end
    end
    // Frame summary built from the post-update state.
    cnt_n = (CntW+2)'(cnt_d);
    sum_o.short_frame     = cnt_d < CntW'(14);
    sum_o.ether_kind      = kind_d;
    sum_o.header_words    = hw_d;
    sum_o.ip_total_length = tot_d;
    sum_o.ip_protocol     = prot_d;
    sum_o.ip_sum_acc      = ips_d;
    sum_o.tcp_sum_acc     = tcps_d;
    sum_o.captured        = cap_d;
    sum_o.ip_hdr_done = 18'(cnt_n) >= 18'd14 + 18'({hw_d, 2'b00});
    sum_o.l4_8_done   = 18'(cnt_n) >= 18'd22 + 18'({hw_d, 2'b00});
    sum_o.l4_20_done  = 18'(cnt_n) >= 18'd34 + 18'({hw_d, 2'b00});
    sum_o.tot_done    = 18'(cnt_n) >= 18'd14 + 18'(tot_d);
    sum_o.ip20_done   = 18'(cnt_n) >= 18'd34;
    sum_o.arp_done    = 18'(cnt_n) >= 18'd42;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; kind_q <= '0; hw_q <= '0; tot_q <= '0; prot_q <= '0;
      ips_q <= '0; tcps_q <= '0; pend_q <= '0; cap_q <= '0;
    end else if (take) begin
      if (item_i.frame_end) begin
        cnt_q <= '0; kind_q <= '0; hw_q <= '0; tot_q <= '0; prot_q <= '0;
        ips_q <= '0; tcps_q <= '0; pend_q <= '0; cap_q <= '0;
      end else begin
        cnt_q <= cnt_d; kind_q <= kind_d; hw_q <= hw_d; tot_q <= tot_d;
        prot_q <= prot_d; ips_q <= ips_d; tcps_q <= tcps_d; pend_q <= pend_d;
        cap_q <= cap_d;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/eithp_queue.sv
// Two-entry queue between the front and back ends.
`default_nettype none
module eithp_queue import eithp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire summary_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output summary_t      data_o,
  input  wire logic     ready_i
);
  summary_t   mem_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> src/eithp_back.sv
// Back end: classify a frame summary, finish the TCP sum, register the result.
`default_nettype none
module eithp_back import eithp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire summary_t sum_i,
  output logic          ready_o,
  output logic          valid_o,
  output out_item_t     item_o,
  input  wire logic     ready_i
);
  out_item_t res_d, res_q;
  logic      valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = res_q;

  always_comb begin
    logic [2:0]  cls;
    logic        need_ok, hw5;
    logic [5:0]  hlen;
    logic [15:0] s, seg;
    hlen = {sum_i.header_words, 2'b00};
    hw5 = sum_i.header_words >= 4'd5;
    cls = ClsUnknown;
    need_ok = !sum_i.short_frame;
    if (!sum_i.short_frame && sum_i.ether_kind == EtherArp) begin
      cls = ClsArp; need_ok = sum_i.arp_done;
    end else if (!sum_i.short_frame && sum_i.ether_kind == EtherIpv4) begin
      cls = ClsIpOther;
      need_ok = hw5 ? sum_i.ip_hdr_done : sum_i.ip20_done;
      if (hw5) begin
        case (sum_i.ip_protocol)
          ProtoIcmp: begin cls = ClsIcmp; need_ok = sum_i.l4_8_done; end
          ProtoTcp: begin
            cls = ClsTcp; need_ok = sum_i.l4_20_done && sum_i.tot_done;
          end
          ProtoUdp: begin cls = ClsUdp; need_ok = sum_i.l4_8_done; end
          default: ;
        endcase
      end
    end
    seg = sum_i.ip_total_length - {10'd0, hlen};
    s = oc_add(oc_add(sum_i.tcp_sum_acc, {8'd0, sum_i.ip_protocol}), seg);
    res_d = '0;
    res_d.packet_class = cls;
    res_d.truncated = !need_ok;
    if (cls == ClsArp) res_d.arp_is_reply = sum_i.captured[15:0] == 16'd2;
    if (cls >= ClsIpOther) begin
      res_d.ip_header_bytes = hlen;
      res_d.time_to_live = sum_i.captured[55:48];
      res_d.ip_sum_good = hw5 && sum_i.ip_hdr_done && sum_i.ip_sum_acc == 16'hFFFF;
    end
    if (cls == ClsTcp || cls == ClsUdp) begin
      res_d.source_port = sum_i.captured[15:0];
      res_d.destination_port = sum_i.captured[31:16];
    end
    if (cls == ClsIcmp) res_d.icmp_type_code = sum_i.captured[47:40];
    if (cls == ClsTcp) begin
      res_d.tcp_flag_bits = sum_i.captured[39:32];
      res_d.tcp_sum_good = need_ok && sum_i.ip_total_length >= {10'd0, hlen}
                           && s == 16'hFFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (ready_o) valid_q <= valid_i;
  end
endmodule
`default_nettype wire

>>> src/eth_ip_tcp_header_parser.sv
// Top level of the Ethernet/IPv4/TCP/UDP header parser.
// Usage:
//   Input channel in_valid_i/in_ready_o carries one frame byte per item with
//   a last-byte mark. Output channel out_valid_o/out_ready_i carries one
//   summary item per frame: class, ARP reply flag, IP header length, TTL,
//   IP and TCP checksum verdicts, ports, TCP flags, ICMP type, truncation.
//   Throughput: one byte per cycle unless a last byte is held off; the front end updates counters and
//   running ones-complement sums as each byte is taken.
//   Path: the queue takes the summary at the edge that takes the last byte;
//   the output register takes it from the queue once the back end is ready,
//   and it is offered from there at once.
//   The front end hands the frame summary to a two-entry queue; the back end
//   classifies it and holds it in an output register.
//   When the receiver stalls, the queue and the output register absorb up to
//   three summaries; after that a last byte is held off while non-final bytes
//   still go through.
//   Reset clears all frame state, the queue and the output valid.
//   Bytes beyond MaxFrameBytes are ignored.
`default_nettype none
module eth_ip_tcp_header_parser import eithp_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o
);
  summary_t fe_sum, q_sum;
  logic     fe_valid, q_ready, q_valid, be_ready;

  // The front end stalls only a last byte when the queue has no room.
  eithp_front #(.MaxFrameBytes(MaxFrameBytes)) u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .item_i(in_item_i), .ready_o(in_ready_o),
    .sum_valid_o(fe_valid), .sum_o(fe_sum), .sum_ready_i(q_ready)
  );

  eithp_queue u_queue (
    .clk_i, .rst_ni, .valid_i(fe_valid), .data_i(fe_sum), .ready_o(q_ready),
    .valid_o(q_valid), .data_o(q_sum), .ready_i(be_ready)
  );

  eithp_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .sum_i(q_sum), .ready_o(be_ready),
    .valid_o(out_valid_o), .item_o(out_item_o), .ready_i(out_ready_i)
  );
endmodule
`default_nettype wire

>>> src/eithp_checker.sv
// Port-level checker for the header parser, bound to the top level.
`default_nettype none
`include "eth_ip_tcp_header_parser_defines.svh"
module eithp_checker import eithp_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);
  `EITHP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result dropped or changed while stalled")
  `EITHP_ASSERT_ALWAYS(a_class_range, clk_i, rst_ni, !out_valid_o || out_item_o.packet_class <= ClsUdp, "class code out of range")
  `EITHP_ASSERT_ALWAYS(a_mid_ready, clk_i, rst_ni, in_item_i.frame_end || in_ready_o, "non-final byte refused")
  `EITHP_ASSERT_ALWAYS(a_tcp_only, clk_i, rst_ni, !out_valid_o || !out_item_o.tcp_sum_good || out_item_o.packet_class == ClsTcp, "TCP verdict outside TCP")
endmodule
bind eth_ip_tcp_header_parser eithp_checker u_checker (.*);
`default_nettype wire
